@@ sv/bqen_pkg.sv @@
// Shared types, constants and quad classification for the bit-quad Euler number block.
package bqen_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int IMG_W_W       = 11;
  localparam int COUNT_W       = 21;
  localparam int SUM_W         = COUNT_W + 3;
  localparam int EULER_W       = 20;
  localparam int EULER_LIMIT   = 523264;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_EIGHT_CONN  = 1'b1;

  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST = IMG_W_W'(1024);

  typedef struct packed {
    logic single;
    logic triple;
    logic diag;
    logic last;
  } quad_cls_t;

  typedef struct packed {
    logic [COUNT_W-1:0] single;
    logic [COUNT_W-1:0] triple;
    logic [COUNT_W-1:0] diag;
    logic               eight;
  } counts_t;

  // q = {upper_left, up, left, current}
  function automatic quad_cls_t classify(input logic [3:0] q, input logic formed);
    quad_cls_t c;
    logic [2:0] ones;
    ones = 3'(q[0]) + 3'(q[1]) + 3'(q[2]) + 3'(q[3]);
    c.single = formed && (ones == 3'd1);
    c.triple = formed && (ones == 3'd3);
    c.diag   = formed && ((q == 4'b0110) || (q == 4'b1001));
    c.last   = 1'b0;
    return c;
  endfunction

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c,
                                                 input logic inc);
    logic [COUNT_W-1:0] r;
    r = c;
    if (inc && !(&c)) begin
      r = c + COUNT_W'(1);
    end
    return r;
  endfunction

endpackage

@@ sv/bqen_line_buf.sv @@
// One-row line store with registered read, write bypass and post-reset clearing pass.
module bqen_line_buf #(
  parameter int DEPTH = bqen_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic                     rd_data,
  output logic                     clearing
);

  localparam int AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          rd_q;
  logic          byp;
  logic          byp_data;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;

  assign we = clearing || wr_en;
  assign wa = clearing ? clr_addr : wr_addr;
  assign wd = clearing ? 1'b0 : wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else begin
      byp <= we && (wa == rd_addr);
    end
    byp_data <= wd;
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

@@ sv/bqen_quad.sv @@
// Raster position tracking, 2x2 quad formation and the classified-quad stage register.
module bqen_quad #(
  parameter int MAX_WIDTH = bqen_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_accept,
  input  logic                          pixel,
  input  logic                          last_pixel,
  input  logic [bqen_pkg::IMG_W_W-1:0]  image_width,
  input  logic                          up,
  output logic                          wr_en,
  output logic [$clog2(MAX_WIDTH)-1:0]  wr_addr,
  output logic                          wr_data,
  output logic [$clog2(MAX_WIDTH)-1:0]  rd_addr,
  input  logic                          s1_ready,
  output logic                          s1_valid,
  output bqen_pkg::quad_cls_t           s1_cls
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > bqen_pkg::IMG_W_W) ? CW + 1 : bqen_pkg::IMG_W_W;
  localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

  logic [CW-1:0] column;
  logic [CW-1:0] column_next;
  logic          left_pixel;
  logic          upper_left_pixel;
  logic          row_nz;
  logic [WW-1:0] iw;
  logic [WW-1:0] w_eff;
  logic [WW-1:0] col_inc;
  logic          wrap;
  logic          formed;
  bqen_pkg::quad_cls_t cls;

  assign iw      = WW'(image_width);
  assign w_eff   = (iw == '0) ? WW'(1) : ((iw > MAXW) ? MAXW : iw);
  assign col_inc = WW'(column) + WW'(1);
  assign wrap    = col_inc >= w_eff;
  assign formed  = row_nz && (column != '0);

  always_comb begin
    cls      = bqen_pkg::classify({upper_left_pixel, up, left_pixel, pixel}, formed);
    cls.last = last_pixel;
  end

  always_comb begin
    if (last_pixel || wrap) begin
      column_next = '0;
    end else begin
      column_next = col_inc[CW-1:0];
    end
  end

  assign wr_en   = in_accept;
  assign wr_addr = column;
  assign wr_data = pixel;
  assign rd_addr = in_accept ? column_next : column;

  always_ff @(posedge clk) begin
    if (rst) begin
      column           <= '0;
      left_pixel       <= 1'b0;
      upper_left_pixel <= 1'b0;
      row_nz           <= 1'b0;
    end else if (in_accept) begin
      column <= column_next;
      if (last_pixel) begin
        left_pixel       <= 1'b0;
        upper_left_pixel <= 1'b0;
        row_nz           <= 1'b0;
      end else if (wrap) begin
        left_pixel       <= 1'b0;
        upper_left_pixel <= 1'b0;
        row_nz           <= 1'b1;
      end else begin
        left_pixel       <= pixel;
        upper_left_pixel <= up;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_ready) begin
      s1_valid <= 1'b0;
    end
    if (in_accept) begin
      s1_cls <= cls;
    end
  end

endmodule

@@ sv/bqen_count.sv @@
// Saturating quad counters and the end-of-image count snapshot stage.
module bqen_count (
  input  logic                clk,
  input  logic                rst,
  input  logic                s1_valid,
  input  bqen_pkg::quad_cls_t s1_cls,
  output logic                s1_ready,
  input  logic                eight_connected,
  output logic                s2_valid,
  output bqen_pkg::counts_t   s2_counts,
  input  logic                s2_ready
);

  logic [bqen_pkg::COUNT_W-1:0] single_count;
  logic [bqen_pkg::COUNT_W-1:0] triple_count;
  logic [bqen_pkg::COUNT_W-1:0] diagonal_count;
  logic [bqen_pkg::COUNT_W-1:0] single_next;
  logic [bqen_pkg::COUNT_W-1:0] triple_next;
  logic [bqen_pkg::COUNT_W-1:0] diagonal_next;
  logic                         fire;

  assign s1_ready = !s1_cls.last || !s2_valid || s2_ready;
  assign fire     = s1_valid && s1_ready;

  assign single_next   = bqen_pkg::sat_inc(single_count, s1_cls.single);
  assign triple_next   = bqen_pkg::sat_inc(triple_count, s1_cls.triple);
  assign diagonal_next = bqen_pkg::sat_inc(diagonal_count, s1_cls.diag);

  always_ff @(posedge clk) begin
    if (rst) begin
      single_count   <= '0;
      triple_count   <= '0;
      diagonal_count <= '0;
    end else if (fire) begin
      if (s1_cls.last) begin
        single_count   <= '0;
        triple_count   <= '0;
        diagonal_count <= '0;
      end else begin
        single_count   <= single_next;
        triple_count   <= triple_next;
        diagonal_count <= diagonal_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (fire && s1_cls.last) begin
      s2_valid <= 1'b1;
    end else if (s2_ready) begin
      s2_valid <= 1'b0;
    end
    if (fire && s1_cls.last) begin
      s2_counts.single <= single_next;
      s2_counts.triple <= triple_next;
      s2_counts.diag   <= diagonal_next;
      s2_counts.eight  <= eight_connected;
    end
  end

endmodule

@@ sv/bqen_result.sv @@
// Euler sum, truncating divide by four, clamp and the output register.
module bqen_result (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s2_valid,
  input  bqen_pkg::counts_t                   s2_counts,
  output logic                                s2_ready,
  output logic                                out_valid,
  output logic signed [bqen_pkg::EULER_W-1:0] euler,
  input  logic                                out_ready
);

  localparam int SW = bqen_pkg::SUM_W;
  localparam int EW = SW - 2;
  localparam logic signed [EW-1:0] LIM_P = EW'(bqen_pkg::EULER_LIMIT);
  localparam logic signed [EW-1:0] LIM_N = -EW'(bqen_pkg::EULER_LIMIT);

  logic                 s3_valid;
  logic                 s3_ready;
  logic signed [SW-1:0] s3_sum;
  logic signed [SW-1:0] base;
  logic signed [SW-1:0] dbl;
  logic signed [SW-1:0] sum_next;
  logic signed [SW-1:0] adj;
  logic signed [EW-1:0] quo;
  logic signed [EW-1:0] clamped;

  assign base     = $signed(SW'(s2_counts.single)) - $signed(SW'(s2_counts.triple));
  assign dbl      = $signed({2'b00, s2_counts.diag, 1'b0});
  assign sum_next = s2_counts.eight ? (base - dbl) : (base + dbl);

  assign s3_ready = !out_valid || out_ready;
  assign s2_ready = !s3_valid || s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_valid && s2_ready) begin
      s3_valid <= 1'b1;
    end else if (s3_ready) begin
      s3_valid <= 1'b0;
    end
    if (s2_valid && s2_ready) begin
      s3_sum <= sum_next;
    end
  end

  // round toward zero: bias negatives by three before the arithmetic shift
  assign adj = s3_sum[SW-1] ? (s3_sum + SW'(3)) : s3_sum;
  assign quo = adj[SW-1:2];

  always_comb begin
    if (quo > LIM_P) begin
      clamped = LIM_P;
    end else if (quo < LIM_N) begin
      clamped = LIM_N;
    end else begin
      clamped = quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_valid && s3_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s3_valid && s3_ready) begin
      euler <= clamped[bqen_pkg::EULER_W-1:0];
    end
  end

endmodule

@@ sv/bit_quad_euler_number.sv @@
// Top level: config registers, line store, quad stage, counters and result stage.
// Result path from last_pixel: s1 quad, s2 counts, s3 sum, then the euler register.
// Throughput: one pixel beat per cycle while in_ready is high; the line store has one
// write and one read port. Reset: synchronous; after rst falls a pass zeroes the line
// store while in_ready stays low; config writes are taken throughout.
// Register reset values: image_width 1024, eight_connected 0.
module bit_quad_euler_number #(
  parameter int MAX_WIDTH = bqen_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                pixel,
  input  logic                                last_pixel,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bqen_pkg::EULER_W-1:0] euler,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bqen_pkg::ADDR_W-1:0]         paddr,
  input  logic [bqen_pkg::DATA_W-1:0]         pwdata,
  output logic [bqen_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [bqen_pkg::IMG_W_W-1:0] image_width;
  logic                         eight_connected;
  logic                         cfg_wr;
  logic                         in_accept;
  logic                         clearing;
  logic                         up;
  logic                         wr_en;
  logic [CW-1:0]                wr_addr;
  logic                         wr_data;
  logic [CW-1:0]                rd_addr;
  logic                         s1_valid;
  logic                         s1_ready;
  bqen_pkg::quad_cls_t          s1_cls;
  logic                         s2_valid;
  logic                         s2_ready;
  bqen_pkg::counts_t            s2_counts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= bqen_pkg::IMAGE_WIDTH_RST;
      eight_connected <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        bqen_pkg::REG_IMAGE_WIDTH: begin
          image_width <= pwdata[bqen_pkg::IMG_W_W-1:0];
        end
        bqen_pkg::REG_EIGHT_CONN: begin
          eight_connected <= pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bqen_pkg::REG_IMAGE_WIDTH: prdata = bqen_pkg::DATA_W'(image_width);
      bqen_pkg::REG_EIGHT_CONN:  prdata = bqen_pkg::DATA_W'(eight_connected);
      default:                   prdata = '0;
    endcase
  end

  assign in_ready  = !clearing && (!s1_valid || s1_ready);
  assign in_accept = in_valid && in_ready;

  bqen_line_buf #(
    .DEPTH(MAX_WIDTH)
  ) u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (up),
    .clearing(clearing)
  );

  bqen_quad #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_quad (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .pixel      (pixel),
    .last_pixel (last_pixel),
    .image_width(image_width),
    .up         (up),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .rd_addr    (rd_addr),
    .s1_ready   (s1_ready),
    .s1_valid   (s1_valid),
    .s1_cls     (s1_cls)
  );

  bqen_count u_count (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .s1_cls         (s1_cls),
    .s1_ready       (s1_ready),
    .eight_connected(eight_connected),
    .s2_valid       (s2_valid),
    .s2_counts      (s2_counts),
    .s2_ready       (s2_ready)
  );

  bqen_result u_result (
    .clk      (clk),
    .rst      (rst),
    .s2_valid (s2_valid),
    .s2_counts(s2_counts),
    .s2_ready (s2_ready),
    .out_valid(out_valid),
    .euler    (euler),
    .out_ready(out_ready)
  );

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for bit_quad_euler_number: predicted Euler numbers vs. DUT output.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [bqen_pkg::ADDR_W-1:0] IMAGE_WIDTH_ADDR =
    bqen_pkg::ADDR_W'(4 * bqen_pkg::REG_IMAGE_WIDTH);
  localparam logic [bqen_pkg::ADDR_W-1:0] EIGHT_CONN_ADDR  =
    bqen_pkg::ADDR_W'(4 * bqen_pkg::REG_EIGHT_CONN);
  localparam int ROW_MAX     = 1023;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_WAIT  = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic pixel = 1'b0;
  logic last_pixel = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [bqen_pkg::EULER_W-1:0] euler;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [bqen_pkg::ADDR_W-1:0] paddr = '0;
  logic [bqen_pkg::DATA_W-1:0] pwdata = '0;
  logic [bqen_pkg::DATA_W-1:0] prdata;
  logic pready;

  bit_quad_euler_number dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel), .last_pixel(last_pixel),
    .out_valid(out_valid), .out_ready(out_ready), .euler(euler),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  int send_idle_pct = 37;
  int recv_idle_pct = 68;
  int fail_count = 0;
  int quiet_cycles = 0;

  // predictor state
  logic prev_row [bqen_pkg::MAX_WIDTH_DEF];
  logic left_px = 1'b0;
  logic upleft_px = 1'b0;
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;
  logic [bqen_pkg::COUNT_W-1:0] n_single = '0;
  logic [bqen_pkg::COUNT_W-1:0] n_triple = '0;
  logic [bqen_pkg::COUNT_W-1:0] n_diag = '0;
  logic [bqen_pkg::IMG_W_W-1:0] width_setting = bqen_pkg::IMAGE_WIDTH_RST;
  logic eight_setting = 1'b0;
  logic signed [bqen_pkg::EULER_W-1:0] euler_due [$];
  logic signed [bqen_pkg::EULER_W-1:0] due_val;

  initial begin
    foreach (prev_row[i]) prev_row[i] = 1'b0;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic logic [bqen_pkg::COUNT_W-1:0] bump(logic [bqen_pkg::COUNT_W-1:0] c);
    return (&c) ? c : c + bqen_pkg::COUNT_W'(1);
  endfunction

  function automatic int unsigned active_width();
    int unsigned w;
    w = width_setting;
    if (w < 1) w = 1;
    if (w > bqen_pkg::MAX_WIDTH_DEF) w = bqen_pkg::MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic void track_pixel(logic px, logic lst);
    int unsigned w;
    int unsigned c;
    logic up;
    logic [3:0] q;
    longint s;
    longint d;
    longint e;
    w = active_width();
    c = col_pos;
    if (c >= bqen_pkg::MAX_WIDTH_DEF) c = bqen_pkg::MAX_WIDTH_DEF - 1;
    up = prev_row[c];
    if (row_pos >= 1 && c >= 1) begin
      q = {upleft_px, up, left_px, px};
      case (q)
        4'b0001, 4'b0010, 4'b0100, 4'b1000: n_single = bump(n_single);
        4'b0111, 4'b1011, 4'b1101, 4'b1110: n_triple = bump(n_triple);
        4'b0110, 4'b1001: n_diag = bump(n_diag);
        default: ;
      endcase
    end
    upleft_px = up;
    prev_row[c] = px;
    left_px = px;
    if (c + 1 >= w) begin
      col_pos = 0;
      left_px = 1'b0;
      upleft_px = 1'b0;
      if (row_pos < ROW_MAX) row_pos++;
    end else begin
      col_pos = c + 1;
    end
    if (lst) begin
      s = longint'(n_single) - longint'(n_triple);
      d = 2 * longint'(n_diag);
      s = eight_setting ? s - d : s + d;
      e = s / 4;
      if (e > bqen_pkg::EULER_LIMIT) e = bqen_pkg::EULER_LIMIT;
      if (e < -bqen_pkg::EULER_LIMIT) e = -bqen_pkg::EULER_LIMIT;
      euler_due.push_back(e[bqen_pkg::EULER_W-1:0]);
      n_single = '0;
      n_triple = '0;
      n_diag = '0;
      col_pos = 0;
      row_pos = 0;
      left_px = 1'b0;
      upleft_px = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) track_pixel(pixel, last_pixel);
    if (!rst && out_valid && out_ready) begin
      if (euler_due.size() == 0) begin
        report_mismatch("unexpected euler beat", euler, 0);
      end else begin
        due_val = euler_due.pop_front();
        if (euler !== due_val) report_mismatch("euler", euler, due_val);
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_pixel(logic px, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel <= px;
    last_pixel <= lst;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop sending, wait for every pending Euler result, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (euler_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic apb_write(logic [bqen_pkg::ADDR_W-1:0] a, logic [bqen_pkg::DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (a == IMAGE_WIDTH_ADDR) width_setting = d[bqen_pkg::IMG_W_W-1:0];
    else eight_setting = d[0];
    @(posedge clk);
  endtask

  task automatic apb_read(logic [bqen_pkg::ADDR_W-1:0] a,
                          output logic [bqen_pkg::DATA_W-1:0] d);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= a;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    d = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(logic [bqen_pkg::ADDR_W-1:0] a);
    logic [bqen_pkg::DATA_W-1:0] rd;
    apb_read(a, rd);
    if (a == IMAGE_WIDTH_ADDR) begin
      if (rd[bqen_pkg::IMG_W_W-1:0] !== width_setting)
        report_mismatch("image_width readback", rd[bqen_pkg::IMG_W_W-1:0], width_setting);
    end else if (rd[0] !== eight_setting) begin
      report_mismatch("eight_connected readback", rd[0], eight_setting);
    end
  endtask

  task automatic set_register(logic [bqen_pkg::ADDR_W-1:0] a, int unsigned value);
    apb_write(a, bqen_pkg::DATA_W'(value));
    check_register(a);
  endtask

  task automatic send_image_bits(int n, logic [31:0] bits);
    for (int i = 0; i < n; i++) send_pixel(bits[i], i == n - 1);
  endtask

  task automatic test_register_defaults();
    check_register(IMAGE_WIDTH_ADDR);
    check_register(EIGHT_CONN_ADDR);
  endtask

  task automatic test_corner_images();
    set_register(IMAGE_WIDTH_ADDR, 2);
    set_register(EIGHT_CONN_ADDR, 0);
    send_image_bits(4, 32'b1001);
    send_image_bits(4, 32'b0111);
    settle();
    set_register(EIGHT_CONN_ADDR, 1);
    send_image_bits(4, 32'b0110);
    settle();
    set_register(IMAGE_WIDTH_ADDR, 3);
    set_register(EIGHT_CONN_ADDR, 0);
    send_image_bits(9, 32'b000010000);
    send_image_bits(9, 32'b111101111);
    settle();
    set_register(IMAGE_WIDTH_ADDR, 0);
    send_image_bits(2, 32'b11);
    settle();
    set_register(IMAGE_WIDTH_ADDR, 2047);
    send_image_bits(1, 32'b1);
    settle();
  endtask

  task automatic test_width_change();
    set_register(IMAGE_WIDTH_ADDR, 8);
    set_register(EIGHT_CONN_ADDR, 0);
    for (int i = 0; i < 13; i++) send_pixel($urandom_range(1), 1'b0);
    settle();
    set_register(IMAGE_WIDTH_ADDR, 3);
    for (int i = 0; i < 7; i++) send_pixel($urandom_range(1), i == 6);
    settle();
  endtask

  // width above the line store size, then a narrow width mid-image
  task automatic test_max_width();
    set_register(IMAGE_WIDTH_ADDR, 2047);
    set_register(EIGHT_CONN_ADDR, 1);
    for (int i = 0; i < 40; i++) send_pixel($urandom_range(1), 1'b0);
    settle();
    set_register(IMAGE_WIDTH_ADDR, 5);
    for (int i = 0; i < 12; i++) send_pixel($urandom_range(1), i == 11);
    settle();
  endtask

  task automatic test_tall_image();
    set_register(IMAGE_WIDTH_ADDR, 2);
    set_register(EIGHT_CONN_ADDR, $urandom_range(1));
    for (int i = 0; i < 120; i++)
      send_pixel($urandom_range(1), i == 119);
    settle();
  endtask

  task automatic test_random_images(int pixel_budget);
    int sent;
    int cols;
    int rows;
    int density;
    int n;
    int pick;
    int unsigned reg_w;
    sent = 0;
    while (sent < pixel_budget) begin
      if ($urandom_range(2) == 0) begin
        settle();
        pick = $urandom_range(99);
        if (pick < 3) reg_w = 0;
        else if (pick < 88) reg_w = $urandom_range(8, 1);
        else reg_w = $urandom_range(40, 9);
        set_register(IMAGE_WIDTH_ADDR, reg_w);
        set_register(EIGHT_CONN_ADDR, $urandom_range(1));
      end
      cols = active_width();
      rows = $urandom_range(6, 1);
      density = $urandom_range(100);
      n = cols * rows;
      // some images end early or run over, some drop the last flag entirely
      if ($urandom_range(4) == 0) n = $urandom_range(cols * rows + cols, 1);
      for (int i = 0; i < n; i++)
        send_pixel($urandom_range(99) < density, (i == n - 1) && ($urandom_range(9) != 0));
      sent += n;
      if ($urandom_range(7) == 0) settle();
    end
    settle();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_corner_images();
    test_width_change();
    test_max_width();
    test_tall_image();
    send_idle_pct = 37;
    recv_idle_pct = 68;
    test_random_images(200);
    send_idle_pct = 68;
    recv_idle_pct = 37;
    test_random_images(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_images(200);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
